// ===== hdl/antenna_pair_phase_difference_assert.svh =====
// Assertion helpers shared by the RTL; every property is sampled on clk.
`ifndef ANTENNA_PAIR_PHASE_DIFFERENCE_ASSERT_SVH
`define ANTENNA_PAIR_PHASE_DIFFERENCE_ASSERT_SVH

// Check a consequence in the same cycle, outside of reset.
`define APD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle that follows reset.
`define APD_ASSERT_AFTER_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/apd_pkg.sv =====
`timescale 1ns / 1ps
package apd_pkg;
  localparam int COORD_W = 31;
  localparam int COORD_BITS_DEFAULT = 31;
  localparam int WL_W = 20;
  localparam int PH_W = 16;
  localparam int DIST_W = 32;
  localparam int PD_W = 33;
  localparam logic [WL_W-1:0] WL_RESET = 20'd2204;
  localparam logic [PH_W-1:0] FULL_TURN = 16'd36000;

  typedef logic [WL_W-1:0] wl_t;
  typedef logic [PH_W-1:0] phase_t;
  typedef logic [2:0][COORD_W-1:0] point_t;
endpackage

// ===== hdl/antenna_pair_phase_difference.sv =====
`timescale 1ns / 1ps
// Antenna pair phase difference: distance from a transmitter to two antennas,
// the carrier phase seen at each, the path difference and the wrapped phase
// difference from the closer antenna toward the other.
// Input: drive the nine coordinates and pulse start; a transfer happens at any
// edge with start high and busy low. busy stays low, so one item per cycle.
// Output: done is high for exactly one cycle with the six result fields;
// the receiver takes it in that cycle and cannot hold it off.
// Config: wavelength_mm is written at an edge with cfg_valid and cfg_ready
// high; cfg_ready stays high. Write it only while no item is in flight.
// Pipeline order: differences, squares and sum; the square root over the
// root bits; the remainder over the distance bits; the full-turn multiply;
// the divide by the wavelength; and the output stage.
// Throughput is one item per clock; every stage advances every cycle.
// Reset clears all valid bits and done, and loads the 136 MHz wavelength.
module antenna_pair_phase_difference #(
  parameter int COORD_BITS = apd_pkg::COORD_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [30:0]          source_x,
  input  logic signed [30:0]          source_y,
  input  logic signed [30:0]          source_z,
  input  logic signed [30:0]          antenna_a_x,
  input  logic signed [30:0]          antenna_a_y,
  input  logic signed [30:0]          antenna_a_z,
  input  logic signed [30:0]          antenna_b_x,
  input  logic signed [30:0]          antenna_b_y,
  input  logic signed [30:0]          antenna_b_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [19:0]                 wavelength_mm,
  output logic                        done,
  output logic [31:0]                 distance_a,
  output logic [31:0]                 distance_b,
  output logic [15:0]                 phase_a,
  output logic [15:0]                 phase_b,
  output logic signed [32:0]          path_difference,
  output logic [15:0]                 phase_difference
);
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int PD_W   = apd_pkg::PD_W;

  // Nothing ever stalls: the pipeline and config port always accept.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  apd_pkg::wl_t wavelength;

  always_ff @(posedge clk) begin
    if (rst) begin
      wavelength <= apd_pkg::WL_RESET;
    end else if (cfg_valid) begin
      wavelength <= wavelength_mm;
    end
  end

  apd_pkg::point_t src;
  apd_pkg::point_t ant_a;
  apd_pkg::point_t ant_b;

  assign src   = {source_z, source_y, source_x};
  assign ant_a = {antenna_a_z, antenna_a_y, antenna_a_x};
  assign ant_b = {antenna_b_z, antenna_b_y, antenna_b_x};

  logic              a_valid;
  logic [ROOT_W-1:0] a_dist;
  apd_pkg::phase_t   a_phase;
  logic              b_valid;
  logic [ROOT_W-1:0] b_dist;
  apd_pkg::phase_t   b_phase;

  // Both lanes have identical depth, so their outputs line up.
  apd_lane #(.COORD_BITS(COORD_BITS), .ROOT_W(ROOT_W)) u_lane_a (
    .clk(clk), .rst(rst), .in_valid(start), .src(src), .ant(ant_a),
    .wavelength(wavelength), .out_valid(a_valid), .out_dist(a_dist),
    .out_phase(a_phase)
  );

  apd_lane #(.COORD_BITS(COORD_BITS), .ROOT_W(ROOT_W)) u_lane_b (
    .clk(clk), .rst(rst), .in_valid(start), .src(src), .ant(ant_b),
    .wavelength(wavelength), .out_valid(b_valid), .out_dist(b_dist),
    .out_phase(b_phase)
  );

  apd_pkg::phase_t wrap_diff;
  logic            a_closer;

  // Measure from the closer antenna; a tie counts antenna b as closer.
  always_comb begin
    a_closer = a_dist < b_dist;
    if (a_closer) begin
      wrap_diff = (a_phase <= b_phase) ? (b_phase - a_phase)
                                       : (apd_pkg::FULL_TURN - a_phase + b_phase);
    end else begin
      wrap_diff = (b_phase <= a_phase) ? (a_phase - b_phase)
                                       : (apd_pkg::FULL_TURN - b_phase + a_phase);
    end
  end

  // Output stage: hold each result for its single strobe cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid & b_valid;
    end
    distance_a       <= apd_pkg::DIST_W'(a_dist);
    distance_b       <= apd_pkg::DIST_W'(b_dist);
    phase_a          <= a_phase;
    phase_b          <= b_phase;
    path_difference  <= signed'(PD_W'(a_dist) - PD_W'(b_dist));
    phase_difference <= wrap_diff;
  end

`include "antenna_pair_phase_difference_assert.svh"

  `APD_ASSERT_NOW(a_phase_a_range, done, phase_a <= apd_pkg::FULL_TURN, "phase_a above a full turn")
  `APD_ASSERT_NOW(a_phase_diff_range, done, phase_difference <= apd_pkg::FULL_TURN, "phase_difference above a full turn")
  `APD_ASSERT_NOW(a_path_sign, done && path_difference[PD_W-1], distance_a < distance_b, "negative path difference with a not closer")
  `APD_ASSERT_AFTER_RST(a_done_reset, !done, "done set right after reset")
endmodule

// ===== hdl/apd_sqrt.sv =====
`timescale 1ns / 1ps
module apd_sqrt #(
  parameter int SUM_W = 64,
  parameter int ROOT_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_value,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);
  localparam int T_W = SUM_W + 1;

  logic              vld  [ROOT_W+1];
  logic [SUM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_value;
  assign root[0] = '0;

  // One root bit per stage, most significant first.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int K = ROOT_W - 1 - i;
    logic [T_W-1:0] trial;
    logic           fits;

    always_comb begin
      trial = (T_W'(root[i]) << (K + 1)) + (T_W'(1) << (2 * K));
      fits  = T_W'(rem[i]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= fits ? SUM_W'(T_W'(rem[i]) - trial) : rem[i];
      root[i+1] <= fits ? (root[i] | (ROOT_W'(1) << K)) : root[i];
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
endmodule

// ===== hdl/apd_mod.sv =====
`timescale 1ns / 1ps
module apd_mod #(
  parameter int ROOT_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_dist,
  input  apd_pkg::wl_t      wavelength,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_dist,
  output apd_pkg::wl_t      out_rem
);
  localparam int S_W = apd_pkg::WL_W + 1;

  logic              vld   [ROOT_W+1];
  logic [ROOT_W-1:0] dpipe [ROOT_W+1];
  apd_pkg::wl_t      rem   [ROOT_W+1];

  assign vld[0]   = in_valid;
  assign dpipe[0] = in_dist;
  assign rem[0]   = '0;

  // Restoring remainder: shift in one distance bit per stage.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int B = ROOT_W - 1 - i;
    logic [S_W-1:0] shifted;
    logic           ge;

    always_comb begin
      shifted = {rem[i], dpipe[i][B]};
      ge      = shifted >= S_W'(wavelength);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      dpipe[i+1] <= dpipe[i];
      rem[i+1]   <= ge ? apd_pkg::WL_W'(shifted - S_W'(wavelength))
                       : apd_pkg::WL_W'(shifted);
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_dist  = dpipe[ROOT_W];
  assign out_rem   = rem[ROOT_W];
endmodule

// ===== hdl/apd_scale.sv =====
`timescale 1ns / 1ps
module apd_scale #(
  parameter int ROOT_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_dist,
  input  apd_pkg::wl_t      in_rem,
  input  apd_pkg::wl_t      wavelength,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_dist,
  output apd_pkg::phase_t   out_phase
);
  localparam int WL_W   = apd_pkg::WL_W;
  localparam int PH_W   = apd_pkg::PH_W;
  localparam int PROD_W = WL_W + PH_W;
  localparam int CMP_W  = (ROOT_W > WL_W) ? ROOT_W : WL_W;
  localparam int S_W    = WL_W + 1;

  logic              sel_valid;
  logic [ROOT_W-1:0] sel_dist;
  apd_pkg::wl_t      sel_rem;
  logic              prod_valid;
  logic [ROOT_W-1:0] prod_dist;
  logic [PROD_W-1:0] prod;

  // A distance equal to the wavelength keeps a full turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      sel_valid  <= in_valid;
      prod_valid <= sel_valid;
    end
    sel_dist  <= in_dist;
    sel_rem   <= (CMP_W'(in_dist) == CMP_W'(wavelength)) ? wavelength : in_rem;
    prod_dist <= sel_dist;
    prod      <= PROD_W'(sel_rem) * PROD_W'(apd_pkg::FULL_TURN);
  end

  logic              vld   [PH_W+1];
  logic [ROOT_W-1:0] dpipe [PH_W+1];
  logic [PH_W-1:0]   num   [PH_W+1];
  logic [PH_W-1:0]   quo   [PH_W+1];
  apd_pkg::wl_t      rem   [PH_W+1];

  assign vld[0]   = prod_valid;
  assign dpipe[0] = prod_dist;
  assign num[0]   = prod[PH_W-1:0];
  assign quo[0]   = '0;
  assign rem[0]   = prod[PROD_W-1:PH_W];

  // Divide by the wavelength, one quotient bit per stage.
  for (genvar j = 0; j < PH_W; j++) begin : g_step
    localparam int B = PH_W - 1 - j;
    logic [S_W-1:0] shifted;
    logic           ge;

    always_comb begin
      shifted = {rem[j], num[j][B]};
      ge      = shifted >= S_W'(wavelength);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      dpipe[j+1] <= dpipe[j];
      num[j+1]   <= num[j];
      quo[j+1]   <= ge ? (quo[j] | (PH_W'(1) << B)) : quo[j];
      rem[j+1]   <= ge ? WL_W'(shifted - S_W'(wavelength)) : WL_W'(shifted);
    end
  end

  assign out_valid = vld[PH_W];
  assign out_dist  = dpipe[PH_W];
  assign out_phase = (wavelength == '0) ? '0 : quo[PH_W];
endmodule

// ===== hdl/apd_lane.sv =====
`timescale 1ns / 1ps
module apd_lane #(
  parameter int COORD_BITS = apd_pkg::COORD_BITS_DEFAULT,
  parameter int ROOT_W = COORD_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  apd_pkg::point_t   src,
  input  apd_pkg::point_t   ant,
  input  apd_pkg::wl_t      wavelength,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_dist,
  output apd_pkg::phase_t   out_phase
);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = COORD_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 2 * COORD_BITS + 2;

  logic              mag_valid;
  logic [MAG_W-1:0]  mag [3];
  logic              sq_valid;
  logic [SQ_W-1:0]   sq  [3];
  logic              sum_valid;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    logic signed [DIFF_W-1:0] ea;
    logic signed [DIFF_W-1:0] eb;
    logic signed [DIFF_W-1:0] diff;
    if (rst) begin
      mag_valid <= 1'b0;
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      mag_valid <= in_valid;
      sq_valid  <= mag_valid;
      sum_valid <= sq_valid;
    end
    for (int k = 0; k < 3; k++) begin
      ea     = DIFF_W'(signed'(src[k][COORD_BITS-1:0]));
      eb     = DIFF_W'(signed'(ant[k][COORD_BITS-1:0]));
      diff   = ea - eb;
      mag[k] <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      sq[k]  <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
    end
    sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  logic              root_valid;
  logic [ROOT_W-1:0] root;
  logic              mod_valid;
  logic [ROOT_W-1:0] mod_dist;
  apd_pkg::wl_t      mod_rem;

  apd_sqrt #(.SUM_W(SUM_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(sum_valid), .in_value(sum),
    .out_valid(root_valid), .out_root(root)
  );

  apd_mod #(.ROOT_W(ROOT_W)) u_mod (
    .clk(clk), .rst(rst), .in_valid(root_valid), .in_dist(root),
    .wavelength(wavelength), .out_valid(mod_valid), .out_dist(mod_dist),
    .out_rem(mod_rem)
  );

  apd_scale #(.ROOT_W(ROOT_W)) u_scale (
    .clk(clk), .rst(rst), .in_valid(mod_valid), .in_dist(mod_dist),
    .in_rem(mod_rem), .wavelength(wavelength), .out_valid(out_valid),
    .out_dist(out_dist), .out_phase(out_phase)
  );
endmodule
